FILE: sv/mmdu_pkg.sv
// Shared types, constants and per-step functions for the multiply/divide unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none
package mmdu_pkg;

  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumIterStages = 4;
  localparam int unsigned MaxWidth = 16;
  localparam logic [15:0] MaskWord = 16'hFFFF;
  localparam logic [15:0] MaskByte = 16'h00FF;
  localparam logic [15:0] MsbWord = 16'h8000;
  localparam logic [15:0] MsbByte = 16'h0080;
  localparam logic [15:0] AuxBit = 16'h0010;

  typedef struct packed {
    logic cmd;
    logic signed_op;
    logic word_size;
    logic [31:0] operand_a;
    logic [15:0] operand_b;
    logic rep_negate;
  } in_t;

  typedef struct packed {
    logic [15:0] result_lo;
    logic [15:0] result_hi;
    logic divide_error;
    logic carry_flag;
    logic overflow_flag;
    logic aux_flag;
    logic sign_flag;
    logic parity_flag;
    logic zero_flag;
  } out_t;

  typedef struct packed {
    logic cf;
    logic of;
    logic af;
    logic sf;
    logic pf;
    logic zf;
  } flags_t;

  // Working state carried through the iteration stages.
  typedef struct packed {
    logic is_div;
    logic sgn;
    logic wide;
    logic f1;
    logic derr;
    logic orig_top;
    logic cf;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] b;
    flags_t fl;
  } work_t;

  function automatic logic [15:0] width_mask(input logic wide);
    return wide ? MaskWord : MaskByte;
  endfunction

  function automatic logic [15:0] width_msb(input logic wide);
    return wide ? MsbWord : MsbByte;
  endfunction

  function automatic flags_t szp(input flags_t f, input logic [15:0] r, input logic wide);
    flags_t o;
    o = f;
    o.pf = ~(^r[7:0]);
    o.sf = |(r & width_msb(wide));
    o.zf = (r == 16'h0000);
    return o;
  endfunction

  // Rotate left through carry within the active width.
  function automatic logic [16:0] rcl(input logic [15:0] v, input logic cf, input logic wide);
    logic out_bit;
    logic [15:0] nv;
    out_bit = wide ? v[15] : v[7];
    nv = {v[14:0], cf} & width_mask(wide);
    return {out_bit, nv};
  endfunction

  // Rotate right through carry within the active width.
  function automatic logic [16:0] rcr(input logic [15:0] v, input logic cf, input logic wide);
    logic [15:0] nv;
    nv = {1'b0, v[15:1]};
    if (wide) begin
      nv[15] = cf;
    end else begin
      nv[7] = cf;
    end
    return {v[0], nv};
  endfunction

  function automatic flags_t sub_flags(input logic [15:0] x, input logic [15:0] y,
                                       input logic wide);
    flags_t f;
    logic [15:0] t;
    t = (x - y) & width_mask(wide);
    f = '0;
    f.af = |((x ^ y ^ t) & AuxBit);
    f.of = |(((x ^ y) & (x ^ t)) & width_msb(wide));
    f.cf = (y > x);
    return szp(f, t, wide);
  endfunction

  // One step of the shift-and-add or restoring shift-subtract loop.
  function automatic work_t iter_step(input work_t w_in);
    work_t w;
    logic [16:0] r;
    logic [16:0] sum;
    logic [15:0] s;
    flags_t t;
    w = w_in;
    if (w.is_div) begin
      r = rcl(w.lo, w.cf, w.wide);
      w.lo = r[15:0];
      r = rcl(w.hi, r[16], w.wide);
      w.hi = r[15:0];
      w.cf = r[16];
      s = (w.hi - w.b) & width_mask(w.wide);
      t = sub_flags(w.hi, w.b, w.wide);
      if (w.cf) begin
        w.cf = 1'b0;
        w.hi = s;
      end else begin
        w.fl = t;
        w.cf = t.cf;
        if (!t.cf) begin
          w.hi = s;
        end
      end
    end else begin
      if (w.cf) begin
        sum = {1'b0, w.hi} + {1'b0, w.b};
        w.cf = w.wide ? sum[16] : sum[8];
        w.hi = sum[15:0] & width_mask(w.wide);
      end
      r = rcr(w.hi, w.cf, w.wide);
      w.hi = r[15:0];
      r = rcr(w.lo, r[16], w.wide);
      w.lo = r[15:0];
      w.cf = r[16];
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mmdu_pipe_reg.sv
// One pipeline register with valid bit and stall, holding one work record.
// Depends on mmdu_pkg.
`default_nettype none
module mmdu_pipe_reg (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic valid_in,
  input  wire mmdu_pkg::work_t data_in,
  output logic valid,
  output mmdu_pkg::work_t data
);
  import mmdu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data <= data_in;
    end
  end
endmodule
`default_nettype wire

FILE: sv/mmdu_iter_stage.sv
// Pipeline stage that runs a fixed number of loop steps and registers the result.
// Depends on mmdu_pkg and mmdu_pipe_reg.
`default_nettype none
module mmdu_iter_stage #(
  parameter int unsigned Steps = mmdu_pkg::StepsPerStage
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic valid_in,
  input  wire mmdu_pkg::work_t data_in,
  output logic valid,
  output mmdu_pkg::work_t data
);
  import mmdu_pkg::*;

  work_t stepped;

  // All Steps loop steps run for every operation; byte-width skipping is done by the caller.
  always_comb begin
    stepped = data_in;
    for (int unsigned i = 0; i < Steps; i++) begin
      stepped = iter_step(stepped);
    end
  end

  mmdu_pipe_reg u_reg (
    .clk(clk), .rst(rst), .advance(advance),
    .valid_in(valid_in), .data_in(stepped),
    .valid(valid), .data(data)
  );
endmodule
`default_nettype wire

FILE: sv/microcoded_mul_div_unit.sv
// Pipelined multiply/divide unit: prologue, four iteration stages, epilogue, output.
// One transaction is accepted per cycle while the output is not stalled.
// Byte operations use the first two iteration stages and pass the others through.
// Throughput is set by the stall on the output register; the whole pipe holds on stall.
// Synchronous reset clears all valid bits. Depends on mmdu_pkg and the stage modules.
`default_nettype none
module microcoded_mul_div_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire mmdu_pkg::in_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output mmdu_pkg::out_t out_data
);
  import mmdu_pkg::*;

  logic advance;
  work_t pro;
  logic v0;
  work_t d0;
  logic [NumIterStages:0] vs;
  work_t ds [NumIterStages+1];
  work_t byte_gate [NumIterStages];
  out_t epi;

  assign advance = ~(out_valid & out_stall);
  assign in_stall = ~advance;

  // Prologue: operand setup, pre-negation and the divide overflow check.
  always_comb begin
    logic [15:0] m;
    logic [15:0] msb;
    logic [15:0] a_lo;
    logic [15:0] a_hi;
    logic [16:0] r;
    logic borrow;
    flags_t f;
    m = width_mask(in_data.word_size);
    msb = width_msb(in_data.word_size);
    r = '0;
    borrow = 1'b0;
    f = '0;
    pro = '0;
    pro.is_div = in_data.cmd;
    pro.sgn = in_data.signed_op;
    pro.wide = in_data.word_size;
    pro.f1 = in_data.rep_negate;
    pro.b = in_data.operand_b & m;
    a_lo = in_data.operand_a[15:0] & m;
    a_hi = (in_data.word_size ? in_data.operand_a[31:16] : {8'h00, in_data.operand_a[15:8]});
    if (in_data.cmd) begin
      pro.orig_top = |(a_hi & msb);
      pro.lo = a_lo;
      pro.hi = a_hi;
      if (in_data.signed_op) begin
        if (pro.orig_top) begin
          borrow = (pro.lo != 16'h0000);
          pro.lo = (16'h0000 - pro.lo) & m;
          pro.hi = borrow ? (~pro.hi & m) : ((16'h0000 - pro.hi) & m);
          pro.f1 = ~pro.f1;
        end
        if (|(pro.b & msb)) begin
          pro.b = (16'h0000 - pro.b) & m;
          pro.f1 = ~pro.f1;
        end
      end
      f = sub_flags(pro.hi, pro.b, in_data.word_size);
      pro.fl = f;
      pro.cf = f.cf;
      pro.derr = ~f.cf;
    end else begin
      pro.lo = a_lo;
      pro.cf = |(a_lo & msb);
      if (in_data.signed_op) begin
        if (pro.cf) begin
          pro.lo = (16'h0000 - pro.lo) & m;
          pro.f1 = ~pro.f1;
        end
        if (|(pro.b & msb)) begin
          pro.b = (16'h0000 - pro.b) & m;
          pro.f1 = ~pro.f1;
        end
      end
      r = rcr(pro.lo, pro.cf, in_data.word_size);
      pro.lo = r[15:0];
      pro.cf = r[16];
    end
  end

  mmdu_pipe_reg u_pro (
    .clk(clk), .rst(rst), .advance(advance),
    .valid_in(in_valid), .data_in(pro),
    .valid(v0), .data(d0)
  );

  assign vs[0] = v0;
  assign ds[0] = d0;

  for (genvar g = 0; g < NumIterStages; g++) begin : g_iter
    work_t stage_out;
    logic stage_v;
    mmdu_iter_stage #(.Steps(StepsPerStage)) u_stage (
      .clk(clk), .rst(rst), .advance(advance),
      .valid_in(vs[g]), .data_in(ds[g]),
      .valid(stage_v), .data(stage_out)
    );
    // Stages beyond the byte width, and divides that faulted early, leave the record as is.
    always_ff @(posedge clk) begin
      if (advance) begin
        byte_gate[g] <= ds[g];
      end
    end
    assign vs[g+1] = stage_v;
    assign ds[g+1] =
      ((g * StepsPerStage >= MaxWidth / 2 && !byte_gate[g].wide) ||
       (byte_gate[g].is_div && byte_gate[g].derr)) ? byte_gate[g] : stage_out;
  end

  // Epilogue: final rotate, signed fix-ups and flag settling.
  always_comb begin
    work_t w;
    logic [15:0] m;
    logic [15:0] msb;
    logic [15:0] s;
    logic [15:0] t;
    logic [16:0] r;
    logic borrow;
    logic derr;
    flags_t f;
    w = ds[NumIterStages];
    m = width_mask(w.wide);
    msb = width_msb(w.wide);
    s = '0;
    t = '0;
    r = '0;
    borrow = 1'b0;
    f = w.fl;
    derr = w.derr;
    epi = '0;
    if (w.is_div) begin
      if (!derr) begin
        r = rcl(w.lo, w.cf, w.wide);
        w.lo = r[15:0];
        w.cf = |(w.lo & msb);
        f.cf = w.cf;
        s = ~w.lo & m;
        if (w.sgn) begin
          if (!w.cf) begin
            derr = 1'b1;
          end else begin
            if (w.orig_top) begin
              w.hi = (16'h0000 - w.hi) & m;
            end
            s = w.f1 ? ((w.lo + 16'h0001) & m) : (~w.lo & m);
            f.cf = 1'b0;
            f.of = 1'b0;
          end
        end
        if (!derr) begin
          epi.result_lo = s;
          epi.result_hi = w.hi;
        end
      end
    end else begin
      if (w.f1) begin
        borrow = (w.lo != 16'h0000);
        w.lo = (16'h0000 - w.lo) & m;
        w.hi = borrow ? (~w.hi & m) : ((16'h0000 - w.hi) & m);
      end
      f = '0;
      if (w.sgn) begin
        t = (w.hi + {15'h0000, |(w.lo & msb)});
        f.af = |((w.hi ^ t) & AuxBit);
        s = t & m;
      end else begin
        s = w.hi;
      end
      f = szp(f, s, w.wide);
      f.cf = (s != 16'h0000);
      f.of = (s != 16'h0000);
      epi.result_lo = w.lo;
      epi.result_hi = w.hi;
    end
    epi.divide_error = derr;
    epi.carry_flag = f.cf;
    epi.overflow_flag = f.of;
    epi.aux_flag = f.af;
    epi.sign_flag = f.sf;
    epi.parity_flag = f.pf;
    epi.zero_flag = f.zf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vs[NumIterStages];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= epi;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> $stable(out_data))
    else $error("Result changed while stalled.");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_error |-> out_data.result_lo == 16'h0000 &&
    out_data.result_hi == 16'h0000)
    else $error("Divide error with nonzero result.");
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid && out_stall)
    else $error("Input stalled without output backpressure.");
endmodule
`default_nettype wire
